// ===== sv/frame_average_motion_mask_defines.svh =====
// Assertion helpers used by the frame average motion mask RTL.
`ifndef FRAME_AVERAGE_MOTION_MASK_DEFINES_SVH
`define FRAME_AVERAGE_MOTION_MASK_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fam_pkg.sv =====
package fam_pkg;

  // Block dimensions
  localparam int FRAMES = 8;
  localparam int PIXELS = 16384;

  localparam int PIX_W   = 8;
  localparam int POS_W   = $clog2(PIXELS);
  localparam int SLOT_W  = $clog2(FRAMES);
  localparam int SUM_MAX = 255 * FRAMES;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int THR_W   = 11;
  localparam int DIFF_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

  // Mask codes
  localparam logic [PIX_W-1:0] MASK_ON  = 8'd255;
  localparam logic [PIX_W-1:0] MASK_OFF = 8'd0;

  // Configuration map: register index is paddr[2]
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DIFF_THRESHOLD = 1'b0;

  // One memory row: running sum plus the ring of past values at one position
  typedef struct packed {
    logic [SUM_W-1:0]             sum;
    logic [FRAMES-1:0][PIX_W-1:0] hist;
  } row_t;

  // Item held in the read stage
  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  pix;
    logic              fend;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              fwd;
  } s1_item_t;

endpackage

// ===== sv/frame_average_motion_mask.sv =====
// Per-pixel running-average motion mask.
// in_*  : one gray pixel per request in raster order, in_tlast on the last pixel
//         of a frame. out_*: one mask per pixel (255 motion, 0 still), out_tlast
//         copies in_tlast.
// cfg_* : APB-style port, register 0 (byte address 0) is diff_threshold, the
//         motion threshold times the frame count. Write it while idle.
// Throughput: one pixel per clock while the output is not stalled and no clearing
// pass runs. Each pixel does one read and one write of its position's row (running
// sum plus ring of past frames) in a single dual-port memory; a pixel that follows
// its own position is forwarded. Pipeline: the memory read and the item register
// take the accept edge, then the difference is registered in stage 2 and the
// threshold compare in the output register.
// Reset: control clears at once, then a clearing pass zeros all 16384 memory
// rows, one row per cycle; in_tready stays low during it, config writes are
// still taken.
// Stall: when out_tready is low with a result waiting, all stages hold and
// in_tready drops; nothing is lost or repeated. A new pixel is still taken
// while the result waits if the output is free the same cycle.
`include "frame_average_motion_mask_defines.svh"

module frame_average_motion_mask (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // [7:0] pixel
  input  logic                                in_tlast,  // frame_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata, // [7:0] mask
  output logic                                out_tlast, // mask_frame_end
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fam_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [fam_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [fam_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  logic                       adv;
  logic                       accept;
  logic                       cfg_wr;

  logic [fam_pkg::THR_W-1:0]  thr_r;
  logic                       clearing_r;
  logic [fam_pkg::POS_W-1:0]  clear_addr_r;
  logic [fam_pkg::POS_W-1:0]  pos_r;
  logic [fam_pkg::POS_W-1:0]  pos_nxt;
  logic [fam_pkg::SLOT_W-1:0] slot_r;
  logic [fam_pkg::SLOT_W-1:0] slot_nxt;

  fam_pkg::s1_item_t          s1_r;
  fam_pkg::row_t              fwd_row_r;
  fam_pkg::row_t              rd_row;
  fam_pkg::row_t              new_row;
  logic [fam_pkg::SUM_W-1:0]  diff;

  logic                       s2_valid_r;
  logic [fam_pkg::SUM_W-1:0]  s2_diff_r;
  logic                       s2_fend_r;

  logic                       out_valid_r;
  logic [fam_pkg::PIX_W-1:0]  out_mask_r;
  logic                       out_fend_r;

  logic                       mem_we;
  logic [fam_pkg::POS_W-1:0]  mem_waddr;
  fam_pkg::row_t              mem_wdata;

  // Handshake: whole pipeline moves when the output register is free
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && !clearing_r;
  assign accept    = in_tvalid && in_tready;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[fam_pkg::CFG_ADDR_W-1] == fam_pkg::REG_DIFF_THRESHOLD)
                    ? fam_pkg::CFG_DATA_W'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr && cfg_paddr[fam_pkg::CFG_ADDR_W-1] == fam_pkg::REG_DIFF_THRESHOLD) begin
      thr_r <= cfg_pwdata[fam_pkg::THR_W-1:0];
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clear_addr_r <= '0;
    end else if (clearing_r) begin
      if (clear_addr_r == fam_pkg::POS_W'(fam_pkg::PIXELS - 1)) begin
        clearing_r <= 1'b0;
      end
      clear_addr_r <= clear_addr_r + 1'b1;
    end
  end

  // Raster position and ring slot
  always_comb begin
    pos_nxt  = pos_r;
    slot_nxt = slot_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt  = '0;
        slot_nxt = (slot_r == fam_pkg::SLOT_W'(fam_pkg::FRAMES - 1)) ? '0 : slot_r + 1'b1;
      end else begin
        pos_nxt  = (pos_r == fam_pkg::POS_W'(fam_pkg::PIXELS - 1)) ? '0 : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      slot_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Row memory: read on accept, write back from the read stage, zeros while clearing
  assign mem_we    = clearing_r || (adv && s1_r.valid);
  assign mem_waddr = clearing_r ? clear_addr_r : s1_r.pos;
  assign mem_wdata = clearing_r ? '0 : new_row;

  fam_row_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (accept),
    .raddr   (pos_r),
    .rdata_r (rd_row)
  );

  // Stage 1: item beside its memory row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_r.valid <= accept;
      end
      if (accept) begin
        s1_r.pix  <= in_tdata;
        s1_r.fend <= in_tlast;
        s1_r.slot <= slot_r;
        s1_r.pos  <= pos_r;
        // the row written this edge is not yet in the read data
        s1_r.fwd  <= s1_r.valid && (s1_r.pos == pos_r);
        fwd_row_r <= new_row;
      end
    end
  end

  fam_row_update u_update (
    .item    (s1_r),
    .rd_row  (rd_row),
    .fwd_row (fwd_row_r),
    .new_row (new_row),
    .diff    (diff)
  );

  // Stage 2: difference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_diff_r <= diff;
      s2_fend_r <= s1_r.fend;
    end
  end

  // Stage 3: threshold compare into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mask_r <= (fam_pkg::DIFF_W'(s2_diff_r) >= fam_pkg::DIFF_W'(thr_r))
                  ? fam_pkg::MASK_ON : fam_pkg::MASK_OFF;
      out_fend_r <= s2_fend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mask_r;
  assign out_tlast  = out_fend_r;

  // Checks
  `FAM_ASSERT_NEXT(a_frame_end_restarts, clk, rst_n, accept && in_tlast, pos_r == '0, "position not restarted after frame end")
  `FAM_ASSERT_NOW(a_clear_length, clk, rst_n, $fell(clearing_r), $past(clear_addr_r) == fam_pkg::POS_W'(fam_pkg::PIXELS - 1), "clearing pass ended early")
  `FAM_ASSERT_NOW(a_sum_bound, clk, rst_n, s1_r.valid, new_row.sum <= fam_pkg::SUM_W'(fam_pkg::SUM_MAX), "running sum out of range")

endmodule

// ===== sv/fam_row_ram.sv =====
module fam_row_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [fam_pkg::POS_W-1:0] waddr,
  input  fam_pkg::row_t             wdata,
  input  logic                      re,
  input  logic [fam_pkg::POS_W-1:0] raddr,
  output fam_pkg::row_t             rdata_r
);

  fam_pkg::row_t mem [fam_pkg::PIXELS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== sv/fam_row_update.sv =====
module fam_row_update (
  input  fam_pkg::s1_item_t         item,
  input  fam_pkg::row_t             rd_row,
  input  fam_pkg::row_t             fwd_row,
  output fam_pkg::row_t             new_row,
  output logic [fam_pkg::SUM_W-1:0] diff
);

  fam_pkg::row_t             cur_row;
  logic [fam_pkg::PIX_W-1:0] oldest;
  logic [fam_pkg::SUM_W-1:0] scaled;

  // Take the row just written when the previous request hit the same position
  assign cur_row = item.fwd ? fwd_row : rd_row;
  assign oldest  = cur_row.hist[item.slot];
  assign scaled  = fam_pkg::SUM_W'(item.pix) * fam_pkg::SUM_W'(fam_pkg::FRAMES);

  // Absolute difference between the sum and the scaled pixel
  assign diff = (cur_row.sum >= scaled) ? (cur_row.sum - scaled) : (scaled - cur_row.sum);

  // Swap the oldest value for the new one
  always_comb begin
    new_row                = cur_row;
    new_row.sum            = cur_row.sum - fam_pkg::SUM_W'(oldest)
                           + fam_pkg::SUM_W'(item.pix);
    new_row.hist[item.slot] = item.pix;
  end

endmodule

// ===== test/frame_average_motion_mask_tb.sv =====
module frame_average_motion_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Sets the settle wait after a drain
  localparam int PIPE_LATENCY   = 2;
  // Quiet cycles allowed; covers the clearing pass after reset
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int IDLE_PCT       = 35;

  // Register map: threshold at index 0; index 1 does not exist
  localparam logic [fam_pkg::CFG_ADDR_W-1:0] THRESH_ADDR = 3'd0;
  localparam logic [fam_pkg::CFG_ADDR_W-1:0] SPARE_ADDR  = 3'd4;

  typedef struct packed {
    logic [fam_pkg::PIX_W-1:0] mask;
    logic                      last;
  } mask_res_t;

  // Running-average predictor plus the queue of masks still owed by the block
  class motion_mask_checker;
    bit [fam_pkg::THR_W-1:0] threshold;
    bit [fam_pkg::SUM_W-1:0] sums [fam_pkg::PIXELS];
    bit [fam_pkg::PIX_W-1:0] history [fam_pkg::FRAMES*fam_pkg::PIXELS];
    int unsigned             position;
    int unsigned             slot;
    mask_res_t               masks_due [$];
    int                      errors;
    int                      motion_seen;
    int                      still_seen;
    int                      frames_seen;

    // Work out the mask for an accepted pixel, then fold the pixel in
    function void take_pixel(logic [fam_pkg::PIX_W-1:0] pix, logic fend);
      logic [fam_pkg::POS_W-1:0]                pos;
      logic [fam_pkg::SLOT_W+fam_pkg::POS_W-1:0] idx;
      int                                       sum, scaled, diff;
      mask_res_t                                due;
      pos    = fam_pkg::POS_W'(position % fam_pkg::PIXELS);
      idx    = {fam_pkg::SLOT_W'(slot % fam_pkg::FRAMES), pos};
      sum    = int'(sums[pos]);
      scaled = int'(pix) * fam_pkg::FRAMES;
      diff   = (sum >= scaled) ? sum - scaled : scaled - sum;
      due.mask = (diff >= int'(threshold)) ? fam_pkg::MASK_ON : fam_pkg::MASK_OFF;
      due.last = fend;
      masks_due.push_back(due);
      sums[pos]    = fam_pkg::SUM_W'(sum - int'(history[idx]) + int'(pix));
      history[idx] = pix;
      if (fend) begin
        position = 0;
        slot     = (slot + 1) % fam_pkg::FRAMES;
        frames_seen++;
      end else begin
        position = (int'(pos) + 1) % fam_pkg::PIXELS;
      end
    endfunction

    // Compare one result against the oldest owed mask
    function void check_mask(logic [fam_pkg::PIX_W-1:0] mask, logic last);
      mask_res_t due;
      if (masks_due.size() == 0) begin
        $error("unexpected result: mask %0d, tlast %b", mask, last);
        errors++;
        return;
      end
      due = masks_due.pop_front();
      if (mask !== due.mask) begin
        $error("mask: expected %0d, actual %0d", due.mask, mask);
        errors++;
      end
      if (last !== due.last) begin
        $error("mask_frame_end: expected %b, actual %b", due.last, last);
        errors++;
      end
      if (due.mask == fam_pkg::MASK_ON) motion_seen++;
      else still_seen++;
    endfunction
  endclass

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata    = '0;  // [7:0] pixel
  logic                           in_tlast    = 1'b0; // frame_end
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [7:0]                     out_tdata;          // [7:0] mask
  logic                           out_tlast;          // mask_frame_end
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [fam_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [fam_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [fam_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  motion_mask_checker masks = new();
  bit                 calm;          // no idling on either side while set
  int                 quiet_cycles;
  int                 thresh_writes;
  logic [7:0]         base [64];     // per-position background for random frames

  frame_average_motion_mask uut (.*);

  always #5 clk = ~clk;

  // Result side: random backpressure, check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) masks.check_mask(out_tdata, out_tlast);
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on cycles without any transfer on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [7:0] pix, input logic fend);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tlast  <= fend;
    do @(posedge clk); while (!in_tready);
    masks.take_pixel(pix, fend);
  endtask

  // Stop sending and wait until every owed mask has come back
  task automatic drain(input bit settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (masks.masks_due.size() != 0);
    if (settle) repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fam_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [fam_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == THRESH_ADDR) begin
      masks.threshold = data[fam_pkg::THR_W-1:0];
      thresh_writes++;
    end
  endtask

  // Mostly a noisy static background, with jumps, extremes and scene changes
  function automatic logic [7:0] next_pixel(int p);
    int roll, v;
    roll = $urandom_range(99);
    if (roll < 60) begin
      v = int'(base[p[5:0]]) + int'($urandom_range(12)) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    end
    if (roll < 80) return 8'($urandom_range(255));
    if (roll < 90) return roll[0] ? 8'd255 : 8'd0;
    base[p[5:0]] = 8'($urandom_range(255));
    return base[p[5:0]];
  endfunction

  // Frames of one length per run, with some cut short; run ends on a frame end
  task automatic run_frames(input int count, input bit pause_midway);
    int         frame_len, p, n;
    logic [7:0] pix;
    logic       fend;
    frame_len = $urandom_range(4, 24);
    p = 0;
    for (n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) drain(0);
      pix  = next_pixel(p);
      fend = (p == frame_len - 1) || (n == count - 1) || ($urandom_range(99) < 6);
      send_pixel(pix, fend);
      p = fend ? 0 : p + 1;
    end
  endtask

  initial begin
    foreach (base[i]) base[i] = 8'($urandom_range(255));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Zero threshold from reset: every pixel is motion
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b1);      // one-pixel frame
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b1);
    drain(1);

    // Threshold equal to the full-scale sum: only a full-scale difference trips it
    write_reg(THRESH_ADDR, 32'd2040);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b1);
    drain(1);

    // A write to a register that does not exist must leave the threshold alone
    write_reg(SPARE_ADDR, 32'h0000_07FF);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    drain(1);

    write_reg(THRESH_ADDR, 32'd1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd1, 1'b1);
    drain(1);

    // Random frames under several thresholds; one run without idling,
    // one with a pause until the block is empty
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_reg(THRESH_ADDR, 32'd2040);
        1:       write_reg(THRESH_ADDR, 32'd1);
        default: write_reg(THRESH_ADDR, $urandom_range(8, 160));
      endcase
      calm = (ph == 3);
      run_frames(200, ph == 2);
      drain(1);
    end
    calm = 0;

    $display("Checked %0d frames at %0d threshold settings, with short and one-pixel frames;",
             masks.frames_seen, thresh_writes);
    $display("%0d motion and %0d still masks compared.", masks.motion_seen, masks.still_seen);
    if (masks.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== frame_average_motion_mask.f =====
+incdir+sv
sv/fam_pkg.sv
sv/fam_row_ram.sv
sv/fam_row_update.sv
sv/frame_average_motion_mask.sv
test/frame_average_motion_mask_tb.sv
